>>> rtl/tlvx_pkg.sv
// Shared types, tag and code constants, and helpers for the TLV application-info extractor.
`timescale 1ns / 1ps
`default_nettype none
package tlvx_pkg;

	localparam logic [7:0] TAG_TEMPLATE     = 8'hA4;
	localparam logic [7:0] TAG_PREINIT      = 8'h80;
	localparam logic [7:0] TAG_INST_ID      = 8'h8F;
	localparam logic [7:0] TAG_PUBKEY       = 8'h80;
	localparam logic [7:0] TAG_KEY_ID       = 8'h8E;
	localparam logic [7:0] TAG_INTEGER      = 8'h02;
	localparam logic [7:0] LEN_EXT1         = 8'h81;
	localparam logic [7:0] LEN_EXT2         = 8'h82;

	localparam logic [2:0] FIELD_INSTANCE_UID = 3'd0;
	localparam logic [2:0] FIELD_PUBLIC_KEY   = 3'd1;
	localparam logic [2:0] FIELD_VERSION      = 3'd2;
	localparam logic [2:0] FIELD_SLOTS        = 3'd3;
	localparam logic [2:0] FIELD_KEY_UID      = 3'd4;
	localparam logic [2:0] FIELD_NONE         = 3'd7;

	localparam logic ITEM_VALUE   = 1'b0;
	localparam logic ITEM_SUMMARY = 1'b1;

	localparam logic [1:0] CARD_PREINIT  = 2'd0;
	localparam logic [1:0] CARD_TEMPLATE = 2'd1;
	localparam logic [1:0] CARD_WRONG    = 2'd2;

	localparam logic [4:0] PREINIT_MASK = 5'b00010;

	localparam int OUTQ_DEPTH = 8;

	typedef struct packed {
		logic        item_kind;
		logic [2:0]  field_code;
		logic [15:0] byte_offset;
		logic [7:0]  value_byte;
		logic [4:0]  complete_mask;
		logic [1:0]  card_state;
		logic        final_item;
	} result_t;

	typedef struct packed {
		logic    value_valid;
		result_t value_item;
		logic    summary_valid;
		result_t summary_item;
	} step_out_t;

	function automatic logic [2:0] field_of(logic [7:0] tag, logic [1:0] int_count);
		logic [2:0] f;
		f = FIELD_NONE;
		case (tag)
			TAG_INST_ID:  f = FIELD_INSTANCE_UID;
			TAG_PUBKEY:   f = FIELD_PUBLIC_KEY;
			TAG_KEY_ID:   f = FIELD_KEY_UID;
			TAG_INTEGER: begin
				if (int_count == 2'd1) f = FIELD_VERSION;
				else if (int_count == 2'd2) f = FIELD_SLOTS;
				else f = FIELD_NONE;
			end
			default: f = FIELD_NONE;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

>>> rtl/tlvx_parser.sv
// Parser state registers and the single-step TLV walk for one response word.
`timescale 1ns / 1ps
`default_nettype none
module tlvx_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire logic [7:0]        byte_in,
	input  wire logic              end_in,
	output tlvx_pkg::step_out_t    step_out
);

	typedef enum logic [2:0] {
		OP_FIRST, OP_PRESKIP, OP_PREKEY, OP_LEN, OP_LEN81, OP_LEN82H, OP_LEN82L, OP_BODY
	} outer_t;

	typedef enum logic [2:0] {
		IP_TAG, IP_LEN, IP_LEN81, IP_LEN82H, IP_LEN82L, IP_VALUE
	} inner_t;

	outer_t      outer_q, outer_n;
	inner_t      inner_q, inner_n;
	logic [15:0] tmpl_rem_q, tmpl_rem_n;
	logic [7:0]  child_tag_q, child_tag_n;
	logic [15:0] child_rem_q, child_rem_n;
	logic [15:0] child_off_q, child_off_n;
	logic [4:0]  seen_q, seen_n;
	logic [4:0]  done_q, done_n;
	logic [1:0]  int_count_q, int_count_n;
	logic [1:0]  card_q, card_n;

	logic        do_start;
	logic [15:0] start_len;
	logic        do_finish;
	logic [2:0]  cur_field;
	logic [2:0]  fin_field;
	logic [4:0]  seen_bit;
	logic        under_cap;
	logic        fin_ok;
	logic [4:0]  sum_mask;

	always_comb begin
		outer_n     = outer_q;
		inner_n     = inner_q;
		tmpl_rem_n  = tmpl_rem_q;
		child_tag_n = child_tag_q;
		child_rem_n = child_rem_q;
		child_off_n = child_off_q;
		seen_n      = seen_q;
		done_n      = done_q;
		int_count_n = int_count_q;
		card_n      = card_q;
		do_start    = 1'b0;
		start_len   = 16'd0;
		do_finish   = 1'b0;
		fin_ok      = 1'b0;
		sum_mask    = 5'd0;
		step_out    = '0;

		cur_field = tlvx_pkg::field_of(child_tag_q, int_count_q);
		if (cur_field == tlvx_pkg::FIELD_VERSION) under_cap = (child_off_q < 16'd2);
		else if (cur_field == tlvx_pkg::FIELD_SLOTS) under_cap = (child_off_q < 16'd1);
		else under_cap = 1'b1;

		if (byte_in == tlvx_pkg::TAG_INST_ID) seen_bit = 5'b00001;
		else if (byte_in == tlvx_pkg::TAG_PUBKEY) seen_bit = 5'b00010;
		else seen_bit = 5'b10000;

		case (outer_q)
			OP_FIRST: begin
				if (byte_in == tlvx_pkg::TAG_PREINIT) begin
					card_n  = tlvx_pkg::CARD_PREINIT;
					outer_n = OP_PRESKIP;
				end else if (byte_in == tlvx_pkg::TAG_TEMPLATE) begin
					card_n  = tlvx_pkg::CARD_TEMPLATE;
					outer_n = OP_LEN;
				end else begin
					card_n     = tlvx_pkg::CARD_WRONG;
					tmpl_rem_n = 16'd0;
					outer_n    = OP_BODY;
				end
			end
			OP_PRESKIP: begin
				child_off_n = 16'd0;
				outer_n     = OP_PREKEY;
			end
			OP_PREKEY: begin
				step_out.value_valid            = 1'b1;
				step_out.value_item.item_kind   = tlvx_pkg::ITEM_VALUE;
				step_out.value_item.field_code  = tlvx_pkg::FIELD_PUBLIC_KEY;
				step_out.value_item.byte_offset = child_off_q;
				step_out.value_item.value_byte  = byte_in;
				child_off_n = child_off_q + 16'd1;
			end
			OP_LEN: begin
				if (byte_in == tlvx_pkg::LEN_EXT1) outer_n = OP_LEN81;
				else if (byte_in == tlvx_pkg::LEN_EXT2) outer_n = OP_LEN82H;
				else begin
					tmpl_rem_n = {8'd0, byte_in};
					outer_n    = OP_BODY;
				end
			end
			OP_LEN81: begin
				tmpl_rem_n = {8'd0, byte_in};
				outer_n    = OP_BODY;
			end
			OP_LEN82H: begin
				tmpl_rem_n = {byte_in, 8'd0};
				outer_n    = OP_LEN82L;
			end
			OP_LEN82L: begin
				tmpl_rem_n = {tmpl_rem_q[15:8], byte_in};
				outer_n    = OP_BODY;
			end
			default: begin
				if (tmpl_rem_q != 16'd0) begin
					tmpl_rem_n = tmpl_rem_q - 16'd1;
					case (inner_q)
						IP_TAG: begin
							child_tag_n = byte_in;
							if (byte_in == tlvx_pkg::TAG_INST_ID ||
							    byte_in == tlvx_pkg::TAG_PUBKEY ||
							    byte_in == tlvx_pkg::TAG_KEY_ID) begin
								if ((seen_q & seen_bit) != 5'd0) child_tag_n = 8'd0;
								else seen_n = seen_q | seen_bit;
							end else if (byte_in == tlvx_pkg::TAG_INTEGER) begin
								if (int_count_q != 2'd3) int_count_n = int_count_q + 2'd1;
							end
							inner_n = IP_LEN;
						end
						IP_LEN: begin
							if (byte_in == tlvx_pkg::LEN_EXT1) inner_n = IP_LEN81;
							else if (byte_in == tlvx_pkg::LEN_EXT2) inner_n = IP_LEN82H;
							else begin
								do_start  = 1'b1;
								start_len = {8'd0, byte_in};
							end
						end
						IP_LEN81: begin
							do_start  = 1'b1;
							start_len = {8'd0, byte_in};
						end
						IP_LEN82H: begin
							child_rem_n = {byte_in, 8'd0};
							inner_n     = IP_LEN82L;
						end
						IP_LEN82L: begin
							do_start  = 1'b1;
							start_len = {child_rem_q[15:8], byte_in};
						end
						IP_VALUE: begin
							if (cur_field != tlvx_pkg::FIELD_NONE && under_cap) begin
								step_out.value_valid            = 1'b1;
								step_out.value_item.item_kind   = tlvx_pkg::ITEM_VALUE;
								step_out.value_item.field_code  = cur_field;
								step_out.value_item.byte_offset = child_off_q;
								step_out.value_item.value_byte  = byte_in;
							end
							child_off_n = child_off_q + 16'd1;
							child_rem_n = child_rem_q - 16'd1;
							if (child_rem_n == 16'd0) do_finish = 1'b1;
						end
						default: begin
							inner_n = IP_TAG;
						end
					endcase
				end
			end
		endcase

		if (do_start) begin
			child_rem_n = start_len;
			child_off_n = 16'd0;
			if (start_len == 16'd0) do_finish = 1'b1;
			else inner_n = IP_VALUE;
		end

		fin_field = tlvx_pkg::field_of(child_tag_q, int_count_q);
		if (do_finish) begin
			fin_ok = (fin_field != tlvx_pkg::FIELD_NONE);
			if (fin_field == tlvx_pkg::FIELD_VERSION && child_off_n < 16'd2) fin_ok = 1'b0;
			if (fin_field == tlvx_pkg::FIELD_SLOTS && child_off_n < 16'd1) fin_ok = 1'b0;
			if (fin_ok) done_n = done_n | (5'b00001 << fin_field);
			inner_n = IP_TAG;
		end

		if (end_in) begin
			if (card_n == tlvx_pkg::CARD_PREINIT) sum_mask = tlvx_pkg::PREINIT_MASK;
			else if (card_n == tlvx_pkg::CARD_TEMPLATE) sum_mask = done_n;
			else sum_mask = 5'd0;
			step_out.summary_valid              = 1'b1;
			step_out.summary_item.item_kind     = tlvx_pkg::ITEM_SUMMARY;
			step_out.summary_item.complete_mask = sum_mask;
			step_out.summary_item.card_state    = card_n;
			step_out.summary_item.final_item    = 1'b1;
			outer_n     = OP_FIRST;
			inner_n     = IP_TAG;
			tmpl_rem_n  = 16'd0;
			child_tag_n = 8'd0;
			child_rem_n = 16'd0;
			child_off_n = 16'd0;
			seen_n      = 5'd0;
			done_n      = 5'd0;
			int_count_n = 2'd0;
			card_n      = 2'd0;
		end

		if (!step_en) step_out = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q     <= OP_FIRST;
			inner_q     <= IP_TAG;
			tmpl_rem_q  <= 16'd0;
			child_tag_q <= 8'd0;
			child_rem_q <= 16'd0;
			child_off_q <= 16'd0;
			seen_q      <= 5'd0;
			done_q      <= 5'd0;
			int_count_q <= 2'd0;
			card_q      <= 2'd0;
		end else if (step_en) begin
			outer_q     <= outer_n;
			inner_q     <= inner_n;
			tmpl_rem_q  <= tmpl_rem_n;
			child_tag_q <= child_tag_n;
			child_rem_q <= child_rem_n;
			child_off_q <= child_off_n;
			seen_q      <= seen_n;
			done_q      <= done_n;
			int_count_q <= int_count_n;
			card_q      <= card_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		step_en && end_in |=> outer_q == OP_FIRST && done_q == 5'd0 && seen_q == 5'd0)
		else $error("parser did not return to its reset state after the last word");

	assert property (@(posedge clk) disable iff (!arst_n)
		step_out.value_valid |-> step_en && (outer_q == OP_PREKEY || inner_q == IP_VALUE))
		else $error("value byte produced outside a value phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		step_out.value_valid && step_out.value_item.field_code == tlvx_pkg::FIELD_VERSION
		|-> step_out.value_item.byte_offset < 16'd2)
		else $error("version byte emitted beyond its two-byte cap");

endmodule
`default_nettype wire

>>> rtl/tlvx_outq.sv
// Result queue that takes up to two results per cycle and hands out one per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tlvx_outq #(
	parameter int DEPTH = tlvx_pkg::OUTQ_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [1:0]                 push_cnt,
	input  wire tlvx_pkg::result_t          push_d0,
	input  wire tlvx_pkg::result_t          push_d1,
	input  wire logic                       pop,
	output tlvx_pkg::result_t               head_d,
	output logic                            not_empty,
	output logic [$clog2(DEPTH+1)-1:0]      level
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tlvx_pkg::result_t entries_q [DEPTH];
	logic [PW-1:0]     head_q;
	logic [PW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic [PW-1:0]     tail_p1;
	logic [PW-1:0]     tail_p2;

	function automatic logic [PW-1:0] ptr_next(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign tail_p1   = ptr_next(tail_q);
	assign tail_p2   = ptr_next(tail_p1);
	assign head_d    = entries_q[head_q];
	assign not_empty = (count_q != CW'(0));
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) entries_q[tail_q] <= push_d0;
		if (push_cnt == 2'd2) entries_q[tail_p1] <= push_d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) head_q <= ptr_next(head_q);
			if (push_cnt == 2'd2) tail_q <= tail_p2;
			else if (push_cnt == 2'd1) tail_q <= tail_p1;
			count_q <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from an empty result queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		not_empty && head_d.final_item |-> head_d.item_kind == tlvx_pkg::ITEM_SUMMARY)
		else $error("final flag on a value item");

endmodule
`default_nettype wire

>>> rtl/tlv_application_info_extractor_core.sv
// Top level of the TLV application-info extractor: input register, parser and result queue.
// An accepted word is registered in the input stage; a last word may queue two results.
// One word per cycle while in_stall is low; results drain one per cycle while out_stall is low.
// The input stalls while the result queue lacks room for two results from each word in flight.
// Reset (arst_n low) clears the parser state, the input stage valid and the queue pointers.
// After reset the block expects the first word of a response.
`timescale 1ns / 1ps
`default_nettype none
module tlv_application_info_extractor_core #(
	parameter int OUTQ_DEPTH = tlvx_pkg::OUTQ_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_response,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             item_kind,
	output logic [2:0]       field_code,
	output logic [15:0]      byte_offset,
	output logic [7:0]       value_byte,
	output logic [4:0]       complete_mask,
	output logic [1:0]       card_state,
	output logic             final_item
);

	localparam int CW = $clog2(OUTQ_DEPTH + 1);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                in_accept;
	logic                pop;
	logic [1:0]          push_cnt;
	logic [CW:0]         room_need;
	logic [CW-1:0]       level;
	tlvx_pkg::step_out_t step_out;
	tlvx_pkg::result_t   push_d0;
	tlvx_pkg::result_t   push_d1;
	tlvx_pkg::result_t   head_d;

	assign room_need = {1'b0, level} + (valid_s1 ? (CW+1)'(2) : (CW+1)'(0));
	assign in_stall  = (room_need > (CW+1)'(OUTQ_DEPTH - 2));
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= data_byte;
			end_s1  <= end_of_response;
		end
	end

	tlvx_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (valid_s1),
		.byte_in  (byte_s1),
		.end_in   (end_s1),
		.step_out (step_out)
	);

	always_comb begin
		push_cnt = 2'd0;
		push_d0  = step_out.value_item;
		push_d1  = step_out.summary_item;
		if (step_out.value_valid && step_out.summary_valid) begin
			push_cnt = 2'd2;
		end else if (step_out.value_valid) begin
			push_cnt = 2'd1;
		end else if (step_out.summary_valid) begin
			push_cnt = 2'd1;
			push_d0  = step_out.summary_item;
		end
	end

	assign pop = out_valid && !out_stall;

	tlvx_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_d0   (push_d0),
		.push_d1   (push_d1),
		.pop       (pop),
		.head_d    (head_d),
		.not_empty (out_valid),
		.level     (level)
	);

	assign item_kind     = head_d.item_kind;
	assign field_code    = head_d.field_code;
	assign byte_offset   = head_d.byte_offset;
	assign value_byte    = head_d.value_byte;
	assign complete_mask = head_d.complete_mask;
	assign card_state    = head_d.card_state;
	assign final_item    = head_d.final_item;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && end_s1 |-> step_out.summary_valid)
		else $error("last word of a response produced no summary");

	assert property (@(posedge clk) disable iff (!arst_n)
		step_out.summary_valid |-> valid_s1 && end_s1)
		else $error("summary produced without a last word");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop && level == CW'(1) && push_cnt == 2'd0 |=> !out_valid)
		else $error("result queue shows a word after draining");

endmodule
`default_nettype wire
